// File: design/tba_pkg.sv
// Shared types, field widths and action codes for the timer bank.
package tba_pkg;

    // Default number of timers in the bank.
    localparam int NUM_TIMERS_DEF = 8;

    // Field widths of the command and response items.
    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 32;
    localparam int MASK_W   = 8;

    // Countdown and reload values are held in ticks of 10 ms.
    localparam int CNT_W = 29;

    // Division by ten through a multiply by the rounded reciprocal.
    localparam int               TICK_MS   = 10;
    localparam logic [TIME_W-1:0] DIV_RECIP = 32'hCCCC_CCCD;
    localparam int               DIV_SHIFT = 35;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd4;

    // One command item.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot_number;
        logic [TIME_W-1:0]   time_ms;
        logic                periodic;
        logic                notify;
    } cmd_item_t;

    // One response item.
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] granted_slot;
        logic              expired;
        logic [MASK_W-1:0] fired_mask;
    } rsp_item_t;

    // One timer entry as held in the state memory.
    typedef struct packed {
        logic [CNT_W-1:0] countdown;
        logic [CNT_W-1:0] reload;
        logic             periodic;
        logic             notify;
    } entry_t;

endpackage

// File: design/tba_div10.sv
// Converts a period in milliseconds to 10 ms ticks, with a minimum of one tick.
module tba_div10 (
    input  logic                      clk,
    input  logic                      en,
    input  logic [tba_pkg::TIME_W-1:0] time_ms,
    output logic [tba_pkg::CNT_W-1:0]  ticks
);
    import tba_pkg::*;

    logic [2*TIME_W-1:0] prod;
    logic [CNT_W-1:0]    quo_reg;
    logic                below_one_reg;

    // The product by the reciprocal, shifted down, is exact for all 32-bit inputs.
    assign prod = {{TIME_W{1'b0}}, time_ms} * {{TIME_W{1'b0}}, DIV_RECIP};

    // Capture the quotient and the short-period flag together.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg       <= prod[DIV_SHIFT +: CNT_W];
            below_one_reg <= (time_ms < TIME_W'(TICK_MS));
        end
    end

    // Periods under one tick still count for one tick.
    assign ticks = below_one_reg ? CNT_W'(1) : quo_reg;

endmodule

// File: design/tba_mem.sv
// Timer entry memory: one write port and one registered read port.
module tba_mem #(
    parameter int DEPTH  = tba_pkg::NUM_TIMERS_DEF,
    parameter int ADDR_W = 3
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tba_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output tba_pkg::entry_t     rd_data
);
    import tba_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/timer_bank_alloc_oneshot_periodic_top.sv
// Top level of the timer bank: command sequencer, slot flags and response register.
//
//   Channel | Direction | Handshake            | Payload
//   cmd     | in        | cmd_valid, cmd_stall | cmd (cmd_item_t)
//   rsp     | out       | rsp_valid, rsp_stall | rsp (rsp_item_t)
//
// Register, release and invalid commands pass S_EXEC, then S_DONE; start and check add
// S_MODIFY for a valid slot in use (start only with a nonzero period). A tick walks the
// memory one timer at a time: S_TICK_RD, plus S_TICK_WR for a running one, then S_DONE.
// Reset clears the in-use and running flags at once; the memory needs no clearing.
// The block takes one item at a time; cmd_stall is high while an item is in work,
// and a held response waits in the output register while the next item is accepted.
module timer_bank_alloc_oneshot_periodic_top #(
    parameter int NUM_TIMERS = tba_pkg::NUM_TIMERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  tba_pkg::cmd_item_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tba_pkg::rsp_item_t rsp
);
    import tba_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_MODIFY  = 3'd2;
    localparam logic [2:0] S_TICK_RD = 3'd3;
    localparam logic [2:0] S_TICK_WR = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]            state_reg, state_next;
    cmd_item_t             req_reg;
    rsp_item_t             res_reg, res_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [NUM_TIMERS-1:0] in_use_reg, in_use_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_reg, rsp_next;

    logic                  cmd_accept;
    logic [CNT_W-1:0]      ticks;
    logic [SLOT_W-1:0]     slot_m1;
    logic [IDX_W-1:0]      slot_idx;
    logic                  slot_ok;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  idx_last;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    entry_t                rd_data;

    // Period conversion, started as the item is accepted.
    tba_div10 u_div10 (
        .clk     (clk),
        .en      (cmd_accept),
        .time_ms (cmd.time_ms),
        .ticks   (ticks)
    );

    // Per-timer countdown, reload, mode and notify storage.
    tba_mem #(
        .DEPTH  (NUM_TIMERS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Slot decode for start, check and release.
    assign slot_m1  = req_reg.slot_number - SLOT_W'(1);
    assign slot_idx = slot_m1[IDX_W-1:0];
    assign slot_ok  = (req_reg.slot_number != '0) &&
                      (req_reg.slot_number <= SLOT_W'(NUM_TIMERS));

    assign cnt_dec  = rd_data.countdown - CNT_W'(1);
    assign idx_last = (idx_reg == IDX_W'(NUM_TIMERS - 1));

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Sequencer next-state and memory access logic.
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        in_use_next    = in_use_reg;
        running_next   = running_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_idx;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = slot_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    res_next   = '0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (req_reg.action)
                    ACT_REGISTER:
                    begin
                        if (free_found)
                        begin
                            wr_en                  = 1'b1;
                            wr_addr                = free_idx;
                            wr_data.countdown      = '0;
                            wr_data.reload         = ticks;
                            wr_data.periodic       = req_reg.periodic;
                            wr_data.notify         = req_reg.notify;
                            in_use_next[free_idx]  = 1'b1;
                            running_next[free_idx] = 1'b0;
                            res_next.ok            = 1'b1;
                            res_next.granted_slot  = SLOT_W'(free_idx) + SLOT_W'(1);
                        end
                    end

                    ACT_START:
                    begin
                        if (slot_ok && in_use_reg[slot_idx])
                        begin
                            res_next.ok = 1'b1;
                            if (req_reg.time_ms != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_MODIFY;
                            end
                        end
                    end

                    ACT_CHECK:
                    begin
                        if (slot_ok && in_use_reg[slot_idx])
                        begin
                            rd_en      = 1'b1;
                            state_next = S_MODIFY;
                        end
                    end

                    ACT_RELEASE:
                    begin
                        if (slot_ok)
                        begin
                            in_use_next[slot_idx] = 1'b0;
                            res_next.ok           = 1'b1;
                        end
                    end

                    ACT_TICK:
                    begin
                        res_next.ok = 1'b1;
                        idx_next    = '0;
                        state_next  = S_TICK_RD;
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Second half of start and check, with the entry read back.
            S_MODIFY:
            begin
                state_next = S_DONE;
                if (req_reg.action == ACT_START)
                begin
                    wr_en                  = 1'b1;
                    wr_data.countdown      = ticks;
                    wr_data.reload         = ticks;
                    running_next[slot_idx] = 1'b1;
                end
                else if (rd_data.countdown == '0)
                begin
                    res_next.ok      = 1'b1;
                    res_next.expired = 1'b1;
                end
            end

            // Tick walk: read the entry of an active timer, or skip an idle one.
            S_TICK_RD:
            begin
                if (in_use_reg[idx_reg] && running_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg;
                    state_next = S_TICK_WR;
                end
                else if (idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Tick walk: decrement, then reload or stop at zero.
            S_TICK_WR:
            begin
                wr_en             = 1'b1;
                wr_addr           = idx_reg;
                wr_data.countdown = cnt_dec;
                if (cnt_dec == '0)
                begin
                    if (rd_data.notify && (SLOT_W'(idx_reg) < SLOT_W'(MASK_W)))
                    begin
                        res_next.fired_mask = res_reg.fired_mask |
                                              (MASK_W'(1) << idx_reg);
                    end
                    if (rd_data.periodic)
                    begin
                        wr_data.countdown = rd_data.reload;
                    end
                    else
                    begin
                        running_next[idx_reg] = 1'b0;
                    end
                end
                if (idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_TICK_RD;
                end
            end

            // Hand the response to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            running_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            running_reg   <= running_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            req_reg <= cmd;
        end
        res_reg <= res_next;
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
    end

endmodule
